FILE: sv/unimx_pkg.sv
// ----------------------------------------------------------------------------
// unimx_pkg
// Shared types, field positions and codes for the universal machine
// execute core.
// ----------------------------------------------------------------------------
package unimx_pkg;

    localparam int DATA_W       = 32;
    localparam int REG_W        = 3;
    localparam int NUM_REGS_DEF = 8;
    localparam int FUNC_W       = 2;
    localparam int OP_W         = 4;
    localparam int OP_LSB       = 28;
    localparam int A_LSB        = 6;
    localparam int B_LSB        = 3;
    localparam int C_LSB        = 0;
    localparam int IMM_W        = 25;
    localparam int IMM_REG_LSB  = 25;
    localparam int STATUS_W     = 3;
    localparam int REQ_W        = 3;
    localparam int DIV_STEPS    = DATA_W;
    localparam int CNT_W        = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0] CHAR_MAX = DATA_W'(255);

    // Item kinds.
    localparam logic [FUNC_W-1:0] FN_EXEC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RET  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CHAR = 2'd2;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_CMOV  = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_STORE = 4'd2;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd4;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd5;
    localparam logic [OP_W-1:0] OP_NAND  = 4'd6;
    localparam logic [OP_W-1:0] OP_HALT  = 4'd7;
    localparam logic [OP_W-1:0] OP_MAP   = 4'd8;
    localparam logic [OP_W-1:0] OP_UNMAP = 4'd9;
    localparam logic [OP_W-1:0] OP_OUT   = 4'd10;
    localparam logic [OP_W-1:0] OP_IN    = 4'd11;
    localparam logic [OP_W-1:0] OP_PROG  = 4'd12;
    localparam logic [OP_W-1:0] OP_IMM   = 4'd13;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HALT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADOP = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADIN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd4;

    // Request codes.
    localparam logic [REQ_W-1:0] RQ_NONE  = 3'd0;
    localparam logic [REQ_W-1:0] RQ_LOAD  = 3'd1;
    localparam logic [REQ_W-1:0] RQ_STORE = 3'd2;
    localparam logic [REQ_W-1:0] RQ_MAP   = 3'd3;
    localparam logic [REQ_W-1:0] RQ_UNMAP = 3'd4;
    localparam logic [REQ_W-1:0] RQ_OUT   = 3'd5;
    localparam logic [REQ_W-1:0] RQ_IN    = 3'd6;
    localparam logic [REQ_W-1:0] RQ_PROG  = 3'd7;

    typedef struct packed {
        logic capture;
        logic rd_bc;
        logic rd_a;
        logic exec;
        logic div_step;
        logic div_last;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_store;
        logic div_run;
    } t_stat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REQ_W-1:0]    request;
        logic [DATA_W-1:0]   req_segment;
        logic [DATA_W-1:0]   req_offset;
        logic [DATA_W-1:0]   req_value;
        logic [REG_W-1:0]    req_reg;
        logic                pc_load;
        logic [DATA_W-1:0]   new_pc;
    } t_result;

endpackage

FILE: sv/unimx_dp.sv
// ----------------------------------------------------------------------------
// unimx_dp
// Datapath: item registers, register file, ALU, bit-serial divider and
// result/output registers.
// ----------------------------------------------------------------------------
module unimx_dp
    import unimx_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [DATA_W-1:0]   i_instruction,
    input  logic [REG_W-1:0]    i_dest_reg,
    input  logic [DATA_W-1:0]   i_return_value,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output t_result             o_res
);

    logic [FUNC_W-1:0]  r_func;
    logic [DATA_W-1:0]  r_ins;
    logic [REG_W-1:0]   r_dest;
    logic [DATA_W-1:0]  r_rv;

    logic [DATA_W-1:0]  r_regs [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;

    logic [DATA_W-1:0]  r_rb, r_rc, r_ra;
    logic               r_rb_v, r_rc_v, r_ra_v;
    logic [DATA_W-1:0]  r_quo, r_rem;
    t_result            r_res, r_out;
    t_result            n_res;

    logic [OP_W-1:0]    op;
    logic [REG_W-1:0]   ra_idx, rb_idx, rc_idx;
    logic [DATA_W-1:0]  rb, rc, ra;
    logic [DATA_W-1:0]  prod;
    logic [DATA_W:0]    rem_sh;
    logic [DATA_W+1:0]  diff;
    logic               take;
    logic [DATA_W-1:0]  n_rem, n_quo;
    logic               ex_en, wr_en;
    logic [REG_W-1:0]   ex_addr, wr_addr;
    logic [DATA_W-1:0]  ex_data, wr_data;

    assign op     = r_ins[OP_LSB +: OP_W];
    assign ra_idx = r_ins[A_LSB +: REG_W];
    assign rb_idx = r_ins[B_LSB +: REG_W];
    assign rc_idx = r_ins[C_LSB +: REG_W];

    // Entries never written read as zero.
    assign rb = r_rb_v ? r_rb : '0;
    assign rc = r_rc_v ? r_rc : '0;
    assign ra = r_ra_v ? r_ra : '0;

    // Only the low half of the product is kept, so the multiply wraps.
    assign prod = rb * rc;

    assign o_stat.is_store = (r_func == FN_EXEC) && (op == OP_STORE);
    assign o_stat.div_run  = (r_func == FN_EXEC) && (op == OP_DIV) && (rc != '0);

    // One quotient bit per cycle, restoring form.
    assign rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, rc};
    assign take   = !diff[DATA_W+1];
    assign n_rem  = take ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    assign n_quo  = {r_quo[DATA_W-2:0], take};

    always_comb begin
        n_res   = '0;
        ex_en   = 1'b0;
        ex_addr = r_dest;
        ex_data = r_rv;
        unique case (r_func)
            FN_RET: begin
                ex_en = 1'b1;
            end
            FN_CHAR: begin
                if (r_rv == '1 || r_rv <= CHAR_MAX) begin
                    ex_en = 1'b1;
                end else begin
                    n_res.status = ST_BADIN;
                end
            end
            FN_EXEC: begin
                ex_addr = ra_idx;
                unique case (op)
                    OP_CMOV: begin
                        ex_en   = (rc != '0);
                        ex_data = rb;
                    end
                    OP_LOAD: begin
                        n_res.request     = RQ_LOAD;
                        n_res.req_segment = rb;
                        n_res.req_offset  = rc;
                        n_res.req_reg     = ra_idx;
                    end
                    OP_STORE: begin
                        n_res.request     = RQ_STORE;
                        n_res.req_segment = ra;
                        n_res.req_offset  = rb;
                        n_res.req_value   = rc;
                    end
                    OP_ADD: begin
                        ex_en   = 1'b1;
                        ex_data = rb + rc;
                    end
                    OP_MUL: begin
                        ex_en   = 1'b1;
                        ex_data = prod;
                    end
                    OP_DIV: begin
                        // The quotient is written when the divider finishes.
                        if (rc == '0) begin
                            n_res.status = ST_DIVZ;
                        end
                    end
                    OP_NAND: begin
                        ex_en   = 1'b1;
                        ex_data = ~(rb & rc);
                    end
                    OP_HALT: begin
                        n_res.status = ST_HALT;
                    end
                    OP_MAP: begin
                        n_res.request   = RQ_MAP;
                        n_res.req_value = rc;
                        n_res.req_reg   = rb_idx;
                    end
                    OP_UNMAP: begin
                        n_res.request     = RQ_UNMAP;
                        n_res.req_segment = rc;
                    end
                    OP_OUT: begin
                        n_res.request   = RQ_OUT;
                        n_res.req_value = rc;
                    end
                    OP_IN: begin
                        n_res.request = RQ_IN;
                        n_res.req_reg = rc_idx;
                    end
                    OP_PROG: begin
                        if (rb != '0) begin
                            n_res.request     = RQ_PROG;
                            n_res.req_segment = rb;
                        end
                        n_res.pc_load = 1'b1;
                        n_res.new_pc  = rc;
                    end
                    OP_IMM: begin
                        ex_en   = 1'b1;
                        ex_addr = r_ins[IMM_REG_LSB +: REG_W];
                        ex_data = DATA_W'(r_ins[IMM_W-1:0]);
                    end
                    default: begin
                        n_res.status = ST_BADOP;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ex_addr;
        wr_data = ex_data;
        priority if (i_cmd.div_last) begin
            wr_en   = 1'b1;
            wr_addr = ra_idx;
            wr_data = n_quo;
        end else if (i_cmd.exec) begin
            wr_en = ex_en;
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_ins  <= i_instruction;
            r_dest <= i_dest_reg;
            r_rv   <= i_return_value;
        end
    end

    // Register file: one write port, reads registered.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_regs[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_bc) begin
            r_rb <= r_regs[rb_idx];
            r_rc <= r_regs[rc_idx];
        end
        if (i_cmd.rd_a) begin
            r_ra <= r_regs[ra_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rb_v <= 1'b0;
            r_rc_v <= 1'b0;
            r_ra_v <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_bc) begin
                r_rb_v <= r_vld[rb_idx];
                r_rc_v <= r_vld[rc_idx];
            end
            if (i_cmd.rd_a) begin
                r_ra_v <= r_vld[ra_idx];
            end
        end
    end

    // Divider, result and output registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res <= n_res;
            r_quo <= rb;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_res = r_out;

endmodule

FILE: sv/unimx_ctrl.sv
// ----------------------------------------------------------------------------
// unimx_ctrl
// Controller: sequences capture, register reads, execute, the divide
// iterations and the hand-off into the output register.
// ----------------------------------------------------------------------------
module unimx_ctrl
    import unimx_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_RDA  = 6'b000100,
        S_EXEC = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_bc = 1'b1;
                n_state     = i_stat.is_store ? S_RDA : S_EXEC;
            end
            S_RDA: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.div_run) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    o_cmd.div_last = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                // Hold the finished word until the output register frees up.
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_in_valid |=> (r_state == S_RD))
        else $error("accepted word did not move to register read");

    a_div_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (r_cnt != CNT_LAST)
        |=> (r_state == S_DIV) && (r_cnt == $past(r_cnt) + 1'b1))
        else $error("divide sequence left early or skipped a step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && i_out_stall |=> (r_state == S_DONE))
        else $error("result left done state while output word was stalled");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("output word raised outside done state");

endmodule

FILE: sv/universal_machine_execute_core.sv
// ----------------------------------------------------------------------------
// universal_machine_execute_core
// Execute stage of a 32-bit universal machine with eight registers.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_stall) carries one word: an instruction
// to execute, a returned value to write back, or an input character to write
// back. The output channel (o_out_valid / i_out_stall) carries exactly one
// result word per input word: a status, an optional memory/IO request with
// segment, offset, value and target register, and an optional new program
// counter.
// Each word is captured, reads registers B and C (and A for a store), then
// executes; a divide with a nonzero divisor runs the divider before the
// result is loaded into the output register. The bit-serial divider retires
// one quotient bit per cycle, so a divide takes longest; a store takes longer
// than other words since it needs a third register read. One word is in
// flight at a time; the next is accepted once the previous result has been
// loaded into the output register, while it may still sit there stalled.
// Reset marks every register unwritten, so each reads as zero until written,
// and empties the output register. If the receiver stalls, the result word
// holds and the following word waits in its final state until it is free.
// ----------------------------------------------------------------------------
module universal_machine_execute_core
    import unimx_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [DATA_W-1:0]   i_instruction,
    input  logic [REG_W-1:0]    i_dest_reg,
    input  logic [DATA_W-1:0]   i_return_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [REQ_W-1:0]    o_request,
    output logic [DATA_W-1:0]   o_req_segment,
    output logic [DATA_W-1:0]   o_req_offset,
    output logic [DATA_W-1:0]   o_req_value,
    output logic [REG_W-1:0]    o_req_reg,
    output logic                o_pc_load,
    output logic [DATA_W-1:0]   o_new_pc
);

    t_cmd    cmd;
    t_stat   stat;
    t_result res;

    unimx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    unimx_dp #(
        .NUM_REGS (NUM_REGS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_func         (i_func),
        .i_instruction  (i_instruction),
        .i_dest_reg     (i_dest_reg),
        .i_return_value (i_return_value),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_res          (res)
    );

    assign o_status      = res.status;
    assign o_request     = res.request;
    assign o_req_segment = res.req_segment;
    assign o_req_offset  = res.req_offset;
    assign o_req_value   = res.req_value;
    assign o_req_reg     = res.req_reg;
    assign o_pc_load     = res.pc_load;
    assign o_new_pc      = res.new_pc;

endmodule
